>>> hdl/sat_pkg.sv
`timescale 1ns / 1ps

package sat_pkg;

  // Default geometry
  localparam int unsigned DefaultDepth    = 256;
  localparam int unsigned DefaultKeyWidth = 64;

  // Fixed port widths
  localparam int unsigned FuncW    = 2;
  localparam int unsigned KeyInW   = 64;
  localparam int unsigned PosW     = 8;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned SlotW    = 9;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegKeySigned  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegUniqueKeys = CfgIdxW'(1);

  // Request codes
  typedef enum logic [FuncW-1:0] {
    FnSearch = 2'd0,
    FnInsert = 2'd1,
    FnDelKey = 2'd2,
    FnDelPos = 2'd3
  } func_e;

  // Response codes
  typedef enum logic [StatusW-1:0] {
    StatOk        = 3'd0,
    StatNotFound  = 3'd1,
    StatDuplicate = 3'd2,
    StatFull      = 3'd3,
    StatBadIndex  = 3'd4
  } status_e;

  // Key ordering from the compare unit: request key against stored key
  typedef enum logic [1:0] {
    OrdLt = 2'd0,
    OrdEq = 2'd1,
    OrdGt = 2'd2
  } ord_e;

  // One response beat
  typedef struct packed {
    status_e          status;
    logic             found;
    logic [SlotW-1:0] slot;
    logic [SlotW-1:0] entries;
  } result_t;

endpackage

>>> hdl/sorted_array_table.sv
`timescale 1ns / 1ps
// Search is a binary search: each probe reads the midpoint, compares it and,
// if needed, checks the entry below. Insert and delete then shift entries,
// one per cycle, to open or close a gap.
// One request at a time: busy stays high until the response beat on done_o.
// Reset clears the entry count and config (signed off, unique on); no clearing pass.
// done_o marks each response for one cycle; the receiver cannot stall it.
module sorted_array_table #(
  parameter int unsigned DEPTH     = sat_pkg::DefaultDepth,
  parameter int unsigned KEY_WIDTH = sat_pkg::DefaultKeyWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [sat_pkg::FuncW-1:0]     func_i,
  input  logic [sat_pkg::KeyInW-1:0]    key_i,
  input  logic [sat_pkg::PosW-1:0]      position_i,
  output logic                          done_o,
  output logic [sat_pkg::StatusW-1:0]   status_o,
  output logic                          found_o,
  output logic [sat_pkg::SlotW-1:0]     slot_o,
  output logic [sat_pkg::SlotW-1:0]     entries_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sat_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sat_pkg::CfgDataW-1:0]  cfg_data_i
);
  import sat_pkg::*;

  logic                 key_signed_q;
  logic                 unique_keys_q;
  ord_e                 ord;
  logic [KEY_WIDTH-1:0] cmp_key;
  logic [KEY_WIDTH-1:0] cmp_ref;
  result_t              res;

  // Config registers; writes land only while idle
  assign cfg_ready_o = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_signed_q  <= 1'b0;
      unique_keys_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegKeySigned:  key_signed_q  <= cfg_data_i[0];
        RegUniqueKeys: unique_keys_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Shared key comparator
  sat_cmp #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_cmp (
    .key_a_i      (cmp_key),
    .key_b_i      (cmp_ref),
    .key_signed_i (key_signed_q),
    .ord_o        (ord)
  );

  // Search / shift sequencer with key store
  sat_ctrl #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .func_i        (func_i),
    .key_i         (key_i[KEY_WIDTH-1:0]),
    .position_i    (position_i),
    .unique_keys_i (unique_keys_q),
    .ord_i         (ord),
    .cmp_key_o     (cmp_key),
    .cmp_ref_o     (cmp_ref),
    .done_o        (done_o),
    .res_o         (res)
  );

  assign status_o  = res.status;
  assign found_o   = res.found;
  assign slot_o    = res.slot;
  assign entries_o = res.entries;

endmodule

>>> hdl/sat_cmp.sv
`timescale 1ns / 1ps

module sat_cmp #(
  parameter int unsigned KEY_WIDTH = sat_pkg::DefaultKeyWidth
) (
  input  logic [KEY_WIDTH-1:0] key_a_i,
  input  logic [KEY_WIDTH-1:0] key_b_i,
  input  logic                 key_signed_i,
  output sat_pkg::ord_e        ord_o
);
  import sat_pkg::*;

  logic [KEY_WIDTH-1:0] flip;
  logic [KEY_WIDTH-1:0] a_adj;
  logic [KEY_WIDTH-1:0] b_adj;

  // Two's complement order is unsigned order with the sign bit inverted
  assign flip  = {key_signed_i, {(KEY_WIDTH-1){1'b0}}};
  assign a_adj = key_a_i ^ flip;
  assign b_adj = key_b_i ^ flip;

  always_comb begin
    if (a_adj == b_adj) begin
      ord_o = OrdEq;
    end else if (a_adj > b_adj) begin
      ord_o = OrdGt;
    end else begin
      ord_o = OrdLt;
    end
  end

endmodule

>>> hdl/sat_ctrl.sv
`timescale 1ns / 1ps

module sat_ctrl #(
  parameter int unsigned DEPTH     = sat_pkg::DefaultDepth,
  parameter int unsigned KEY_WIDTH = sat_pkg::DefaultKeyWidth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [sat_pkg::FuncW-1:0]   func_i,
  input  logic [KEY_WIDTH-1:0]        key_i,
  input  logic [sat_pkg::PosW-1:0]    position_i,
  input  logic                        unique_keys_i,
  input  sat_pkg::ord_e               ord_i,
  output logic [KEY_WIDTH-1:0]        cmp_key_o,
  output logic [KEY_WIDTH-1:0]        cmp_ref_o,
  output logic                        done_o,
  output sat_pkg::result_t            res_o
);
  import sat_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    StIdle,
    StProbe,
    StCmpMid,
    StCmpBelow,
    StMove
  } state_e;

  function automatic logic [SlotW-1:0] to_slot(input logic [CW-1:0] v);
    logic [CW+SlotW-1:0] w;
    w = {{SlotW{1'b0}}, v};
    return w[SlotW-1:0];
  endfunction

  state_e               state_q, state_d;
  func_e                func_q, func_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [CW-1:0]        lo_q, lo_d;
  logic [CW-1:0]        hi_q, hi_d;
  logic [CW-1:0]        mid_q, mid_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        n_q, n_d;
  logic [CW-1:0]        r_q, r_d;
  logic [AW-1:0]        wa_q, wa_d;
  logic                 wv_q, wv_d;
  logic                 ins_q, ins_d;
  logic [CW-1:0]        slot_q, slot_d;
  logic                 found_q, found_d;
  logic                 done_q, done_d;
  result_t              res_q, res_d;

  // Key store
  logic [KEY_WIDTH-1:0] mem [DEPTH];
  logic [KEY_WIDTH-1:0] rdata_q;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [KEY_WIDTH-1:0] mem_wd;
  logic [AW-1:0]        mem_ra;

  // Sequencer scratch
  logic [CW:0]          mid_sum;
  logic [CW-1:0]        mid_c;
  logic [CW-1:0]        mid_m1;
  logic [CW-1:0]        r_plus;
  logic [CW-1:0]        r_minus;
  logic [CW+PosW-1:0]   pos_ext;
  logic [CW+PosW-1:0]   cnt_ext;
  logic                 res_go;
  logic [CW-1:0]        res_idx;
  logic                 res_hit;
  logic                 emit;
  status_e              emit_status;
  logic                 emit_found;
  logic [SlotW-1:0]     emit_slot;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_c   = mid_sum[CW:1];
  assign mid_m1  = mid_q - 1'b1;
  assign r_plus  = r_q + 1'b1;
  assign r_minus = r_q - 1'b1;
  assign pos_ext = {{CW{1'b0}}, position_i};
  assign cnt_ext = {{PosW{1'b0}}, cnt_q};

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    key_d       = key_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    r_d         = r_q;
    wa_d        = wa_q;
    wv_d        = wv_q;
    ins_d       = ins_q;
    slot_d      = slot_q;
    found_d     = found_q;
    done_d      = 1'b0;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_wa      = wa_q;
    mem_wd      = rdata_q;
    mem_ra      = r_q[AW-1:0];
    res_go      = 1'b0;
    res_idx     = hi_q;
    res_hit     = 1'b0;
    emit        = 1'b0;
    emit_status = StatOk;
    emit_found  = 1'b0;
    emit_slot   = to_slot(hi_q);

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          func_d = func_e'(func_i);
          key_d  = key_i;
          lo_d   = '0;
          hi_d   = cnt_q;
          if (func_e'(func_i) == FnDelPos) begin
            if (pos_ext >= cnt_ext) begin
              emit        = 1'b1;
              emit_status = StatBadIndex;
              emit_slot   = {{(SlotW-PosW){1'b0}}, position_i};
            end else begin
              // close the gap from the entry above the position
              ins_d   = 1'b0;
              slot_d  = pos_ext[CW-1:0];
              found_d = 1'b0;
              n_d     = cnt_q - pos_ext[CW-1:0] - 1'b1;
              r_d     = pos_ext[CW-1:0] + 1'b1;
              wv_d    = 1'b0;
              state_d = StMove;
            end
          end else begin
            state_d = StProbe;
          end
        end
      end

      // issue a read at the midpoint or end the search
      StProbe: begin
        if (lo_q < hi_q) begin
          mem_ra  = mid_c[AW-1:0];
          mid_d   = mid_c;
          state_d = StCmpMid;
        end else begin
          res_go  = 1'b1;
          res_idx = hi_q;
        end
      end

      StCmpMid: begin
        case (ord_i)
          OrdEq: begin
            res_go  = 1'b1;
            res_idx = mid_q;
            res_hit = 1'b1;
          end
          OrdLt: begin
            if (mid_q == '0) begin
              res_go  = 1'b1;
              res_idx = '0;
            end else begin
              mem_ra  = mid_m1[AW-1:0];
              state_d = StCmpBelow;
            end
          end
          default: begin
            lo_d    = mid_q + 1'b1;
            state_d = StProbe;
          end
        endcase
      end

      // key strictly between the two neighbors: insert point found
      StCmpBelow: begin
        if (ord_i == OrdGt) begin
          res_go  = 1'b1;
          res_idx = mid_q;
        end else begin
          hi_d    = mid_q;
          state_d = StProbe;
        end
      end

      // one entry moved per cycle: read one, write the previous read
      StMove: begin
        if (wv_q) begin
          mem_we = 1'b1;
          mem_wa = wa_q;
          mem_wd = rdata_q;
        end
        if (n_q != '0) begin
          mem_ra = r_q[AW-1:0];
          wv_d   = 1'b1;
          n_d    = n_q - 1'b1;
          if (ins_q) begin
            wa_d = r_plus[AW-1:0];
            r_d  = r_minus;
          end else begin
            wa_d = r_minus[AW-1:0];
            r_d  = r_plus;
          end
        end else begin
          wv_d = 1'b0;
          if (!wv_q) begin
            if (ins_q) begin
              mem_we = 1'b1;
              mem_wa = slot_q[AW-1:0];
              mem_wd = key_q;
              cnt_d  = cnt_q + 1'b1;
            end else begin
              cnt_d  = cnt_q - 1'b1;
            end
            emit        = 1'b1;
            emit_status = StatOk;
            emit_found  = found_q;
            emit_slot   = to_slot(slot_q);
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    // search finished: act on the request
    if (res_go) begin
      unique case (func_q)
        FnSearch: begin
          emit        = 1'b1;
          emit_status = res_hit ? StatOk : StatNotFound;
          emit_found  = res_hit;
          emit_slot   = to_slot(res_idx);
        end
        FnDelKey: begin
          if (!res_hit) begin
            emit        = 1'b1;
            emit_status = StatNotFound;
            emit_slot   = to_slot(res_idx);
          end else begin
            ins_d   = 1'b0;
            slot_d  = res_idx;
            found_d = 1'b1;
            n_d     = cnt_q - res_idx - 1'b1;
            r_d     = res_idx + 1'b1;
            wv_d    = 1'b0;
            state_d = StMove;
          end
        end
        FnInsert: begin
          if (res_hit && unique_keys_i) begin
            emit        = 1'b1;
            emit_status = StatDuplicate;
            emit_found  = 1'b1;
            emit_slot   = to_slot(res_idx);
          end else if (cnt_q == CW'(DEPTH)) begin
            emit        = 1'b1;
            emit_status = StatFull;
            emit_found  = res_hit;
            emit_slot   = to_slot(res_idx);
          end else begin
            // open a gap from the top entry down to the insert point
            ins_d   = 1'b1;
            slot_d  = res_idx;
            found_d = res_hit;
            n_d     = cnt_q - res_idx;
            r_d     = cnt_q - 1'b1;
            wv_d    = 1'b0;
            state_d = StMove;
          end
        end
        default: begin
          state_d = StIdle;
        end
      endcase
    end

    if (emit) begin
      done_d  = 1'b1;
      state_d = StIdle;
      res_d   = '{status:  emit_status,
                  found:   emit_found,
                  slot:    emit_slot,
                  entries: to_slot(cnt_d)};
    end
  end

  // Sequencer state and registered response
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      func_q  <= FnSearch;
      key_q   <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      mid_q   <= '0;
      cnt_q   <= '0;
      n_q     <= '0;
      r_q     <= '0;
      wa_q    <= '0;
      wv_q    <= 1'b0;
      ins_q   <= 1'b0;
      slot_q  <= '0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      func_q  <= func_d;
      key_q   <= key_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      mid_q   <= mid_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      r_q     <= r_d;
      wa_q    <= wa_d;
      wv_q    <= wv_d;
      ins_q   <= ins_d;
      slot_q  <= slot_d;
      found_q <= found_d;
      done_q  <= done_d;
      res_q   <= res_d;
    end
  end

  // Key store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[mem_ra];
  end

  assign busy_o    = (state_q != StIdle);
  assign cmp_key_o = key_q;
  assign cmp_ref_o = rdata_q;
  assign done_o    = done_q;
  assign res_o     = res_q;

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == StIdle))
    else $error("response beat while sequencer still active");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count beyond table depth");

  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ({{(CW-AW+1){1'b0}}, mem_wa} <= {1'b0, cnt_q}))
    else $error("store write above the occupied range");

  a_cnt_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> done_q)
    else $error("entry count changed without a response beat");
`endif

endmodule
